FILE: hw/rtl/led_pattern_sequencer_assert.svh
// Assertion macros for the LED pattern sequencer.
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPS_ASSERT(lbl, prop, msg)
`define LPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/lps_pkg.sv
// Types, constants and helpers shared by the LED pattern sequencer.
package lps_pkg;

  localparam int unsigned LedW  = 8;
  localparam int unsigned ModeW = 4;
  localparam int unsigned RndW  = 6;

  localparam logic [ModeW-1:0] MODE_BIN_UP   = 4'd1;
  localparam logic [ModeW-1:0] MODE_BIN_DN   = 4'd2;
  localparam logic [ModeW-1:0] MODE_GRAY_UP  = 4'd3;
  localparam logic [ModeW-1:0] MODE_GRAY_DN  = 4'd4;
  localparam logic [ModeW-1:0] MODE_BCD_UP   = 4'd5;
  localparam logic [ModeW-1:0] MODE_BCD_DN   = 4'd6;
  localparam logic [ModeW-1:0] MODE_BOUNCE   = 4'd7;
  localparam logic [ModeW-1:0] MODE_STACK    = 4'd8;
  localparam logic [ModeW-1:0] MODE_RANDOM   = 4'd9;
  localparam logic [ModeW-1:0] MODE_FIRST    = MODE_BIN_UP;
  localparam logic [ModeW-1:0] MODE_LAST     = MODE_RANDOM;

  localparam logic [LedW-1:0] FILL_RESET     = 8'h80;
  localparam logic [LedW-1:0] STACK_START    = 8'h01;
  localparam logic [LedW-1:0] BOUNCE_START   = 8'h07;

  // v / 10 == (v * 205) >> 11 for every 8-bit v
  localparam logic [15:0] Div10Mul   = 16'd205;
  localparam int unsigned Div10Shift = 11;
  localparam logic [7:0]  Ten        = 8'd10;

  typedef struct packed {
    logic [LedW-1:0]  pattern;
    logic [LedW-1:0]  count_value;
    logic [LedW-1:0]  fill_mask;
    logic [ModeW-1:0] mode;
    logic             moving_left;
  } lps_state_t;

  function automatic logic [LedW-1:0] gray_of(input logic [LedW-1:0] v);
    return v ^ (v >> 1);
  endfunction

  function automatic logic [LedW-1:0] tens_units_of(input logic [LedW-1:0] v);
    logic [15:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    prod = 16'(v) * Div10Mul;
    quo  = 8'(prod >> Div10Shift);
    rem  = 8'(v - 8'(quo * Ten));
    return {quo[3:0], rem[3:0]};
  endfunction

endpackage

FILE: hw/rtl/lps_if.sv
// Valid/ready channels carrying tick words in and LED words out.
interface lps_in_if;
  import lps_pkg::*;
  logic            valid;
  logic            ready;
  logic            next_btn_before;
  logic            next_btn_after;
  logic            prev_btn_before;
  logic            prev_btn_after;
  logic [RndW-1:0] random_sample;

  modport source (output valid, next_btn_before, next_btn_after, prev_btn_before,
                  prev_btn_after, random_sample, input ready);
  modport sink   (input valid, next_btn_before, next_btn_after, prev_btn_before,
                  prev_btn_after, random_sample, output ready);
endinterface

interface lps_out_if;
  import lps_pkg::*;
  logic            valid;
  logic            ready;
  logic [LedW-1:0] led_pattern;

  modport source (output valid, led_pattern, input ready);
  modport sink   (input valid, led_pattern, output ready);
endinterface

FILE: hw/rtl/lps_step.sv
// Next-state logic for one tick: pattern advance then button mode stepping.
module lps_step import lps_pkg::*; (
  input  lps_state_t      state_i,
  input  logic            next_fall_i,
  input  logic            prev_fall_i,
  input  logic [RndW-1:0] random_i,
  output lps_state_t      state_o
);

  function automatic lps_state_t reload(input lps_state_t s_in);
    lps_state_t s;
    s = s_in;
    if (s.mode == MODE_BOUNCE) begin
      s.pattern = BOUNCE_START;
    end else if (s.mode == MODE_STACK) begin
      s.pattern     = STACK_START;
      s.count_value = STACK_START;
    end else begin
      s.pattern     = '0;
      s.count_value = '0;
    end
    s.fill_mask = FILL_RESET;
    return s;
  endfunction

  always_comb begin
    lps_state_t      s;
    logic [LedW-1:0] inc;
    logic [LedW-1:0] dec;
    logic [LedW-1:0] fm;
    logic [LedW-1:0] cv;
    logic            ml;
    logic [ModeW:0]  m_up;

    s    = state_i;
    inc  = state_i.count_value + 8'd1;
    dec  = state_i.count_value - 8'd1;
    fm   = state_i.fill_mask;
    cv   = state_i.count_value;
    ml   = state_i.moving_left;
    m_up = '0;

    case (state_i.mode)
      MODE_BIN_UP:  begin s.count_value = inc; s.pattern = inc;                end
      MODE_BIN_DN:  begin s.count_value = dec; s.pattern = dec;                end
      MODE_GRAY_UP: begin s.count_value = inc; s.pattern = gray_of(inc);       end
      MODE_GRAY_DN: begin s.count_value = dec; s.pattern = gray_of(dec);       end
      MODE_BCD_UP:  begin s.count_value = inc; s.pattern = tens_units_of(inc); end
      MODE_BCD_DN:  begin s.count_value = dec; s.pattern = tens_units_of(dec); end
      MODE_BOUNCE: begin
        if (state_i.pattern[LedW-1]) ml = 1'b0;
        if (state_i.pattern[0]) ml = 1'b1;
        s.moving_left = ml;
        s.pattern     = ml ? (state_i.pattern << 1) : (state_i.pattern >> 1);
      end
      MODE_STACK: begin
        if (fm[0]) begin
          fm = FILL_RESET;
        end else if (|(cv & fm)) begin
          cv = STACK_START;
          fm = fm | (fm >> 1);
        end else begin
          cv = cv << 1;
        end
        s.fill_mask   = fm;
        s.count_value = cv;
        s.pattern     = {fm[LedW-2:0], 1'b0} | cv;
      end
      MODE_RANDOM: s.pattern = {{(LedW-RndW){1'b0}}, random_i};
      default: ;
    endcase

    if (next_fall_i) begin
      m_up   = {1'b0, s.mode} + 5'd1;
      s.mode = (m_up > {1'b0, MODE_LAST}) ? MODE_FIRST : m_up[ModeW-1:0];
      s      = reload(s);
    end
    if (prev_fall_i) begin
      if (s.mode <= MODE_FIRST || s.mode > MODE_LAST) begin
        s.mode = MODE_LAST;
      end else begin
        s.mode = s.mode - 4'd1;
      end
      s = reload(s);
    end

    state_o = s;
  end

endmodule

FILE: hw/rtl/lps_out_buf.sv
// Output register with a skid stage for LED words.
module lps_out_buf import lps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [LedW-1:0] data_i,
  output logic            ready_o,
  lps_out_if.source       out_o
);

  logic            out_valid_q;
  logic [LedW-1:0] out_data_q;
  logic            skid_valid_q;
  logic [LedW-1:0] skid_data_q;
  logic            pop;

  assign pop             = out_valid_q && out_o.ready;
  assign ready_o         = !skid_valid_q;
  assign out_o.valid     = out_valid_q;
  assign out_o.led_pattern = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_data_q <= skid_data_q;
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_q <= data_i;
      end else begin
        skid_data_q <= data_i;
      end
    end
  end

endmodule

FILE: hw/rtl/led_pattern_sequencer.sv
// LED pattern sequencer: one tick word in, the LED word held at its start out,
// nine pattern modes stepped by falling edges on the next and prev buttons.
// Takes one tick word per clock cycle while ready is high; the mode state updates
// in the cycle a word is accepted; its LED word goes to the two-entry output
// register and skid stage, so input runs on while a result waits, and ready
// drops only when both entries hold words not yet taken.
module led_pattern_sequencer import lps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lps_in_if.sink    in_i,
  lps_out_if.source out_o
);

  `include "led_pattern_sequencer_assert.svh"

  lps_state_t state_q;
  lps_state_t state_d;
  logic       accept;
  logic       buf_ready;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  lps_step u_step (
    .state_i     (state_q),
    .next_fall_i (in_i.next_btn_before && !in_i.next_btn_after),
    .prev_fall_i (in_i.prev_btn_before && !in_i.prev_btn_after),
    .random_i    (in_i.random_sample),
    .state_o     (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pattern     <= '0;
      state_q.count_value <= '0;
      state_q.fill_mask   <= FILL_RESET;
      state_q.mode        <= MODE_FIRST;
      state_q.moving_left <= 1'b1;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  lps_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (state_q.pattern),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  `LPS_ASSERT(a_mode_range, state_q.mode >= MODE_FIRST && state_q.mode <= MODE_LAST,
    "mode left its legal range")
  `LPS_ASSERT(a_fill_top, state_q.fill_mask[LedW-1], "fill mask lost its top bit")
  `LPS_ASSERT(a_accept_out, accept |=> out_o.valid, "accepted word gave no output")
  `LPS_ASSERT(a_idle_hold, !accept |=> $stable(state_q), "state moved without a word")

endmodule
